[hw/rtl/iida_pkg.sv]
// Shared types and codes for the indexed insert/delete array.
// No dependencies; compiled first.
`default_nettype none

package iida_pkg;

	localparam int POS_W   = 8;   // position field width
	localparam int VALUE_W = 32;  // value / read_value field width
	localparam int LEN_W   = 7;   // length field width

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_WRITE  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		act_t               action;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
		logic [LEN_W-1:0]   length;
	} rsp_t;

	// Broadcast to every cell for one request.
	typedef struct packed {
		logic             fire;
		act_t             act;
		logic [POS_W-1:0] at;
	} cmd_t;

	// Read select held while the OR tree settles.
	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] at;
	} sel_t;

endpackage

`default_nettype wire

[hw/rtl/iida_stream_if.sv]
// Valid/ready stream interface used for request and response channels.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface iida_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/indexed_insert_delete_array_core.sv]
// Top level of the indexed insert/delete array: cell chain, read OR tree, control.
// Depends on iida_pkg, iida_stream_if, iida_cell, iida_or_tree.
//
//   channel | dir | payload                           | handshake
//   --------+-----+-----------------------------------+-------------
//   req     | in  | action, position, value           | valid/ready
//   rsp     | out | status, read_value, length        | valid/ready
//
// Flow: a request is taken only in IDLE, then holds in WAIT while the registered OR
//   tree, LEVELS = ceil(log4(DEPTH)) levels deep, gathers the read word from the cell
//   row; shifts are written into the cells as the request is taken.
// Reset: length goes to zero; cell contents are not cleared.
// Stalls: a new request is taken while a response waits; a finished
//   request holds in WAIT until the response register frees up.
`default_nettype none

module indexed_insert_delete_array_core
	import iida_pkg::*;
#(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	iida_stream_if.sink   req,
	iida_stream_if.source rsp
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LEVELS = ($clog2(DEPTH) + 1) / 2;
	localparam int WAIT_W = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WAIT = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [WAIT_W-1:0]  wait_q;
	sel_t               sel_q;
	status_t            status_q;
	logic [LEN_W-1:0]   len_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// request decode
	logic               accept;
	logic [POS_W:0]     pos_x;
	logic [POS_W:0]     cnt_x;
	logic               in_range;
	logic               full;
	logic               ok;
	status_t            status_d;
	logic [CNT_W-1:0]   count_d;
	cmd_t               cmd;
	logic [DATA_W-1:0]  word;
	logic               done;

	assign accept   = req.valid && req.ready;
	assign pos_x    = {1'b0, req.data.position};
	assign cnt_x    = (POS_W + 1)'(count_q);
	assign in_range = pos_x < cnt_x;
	assign full     = count_q == CNT_W'(DEPTH);
	assign word     = DATA_W'(req.data.value);

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		case (req.data.action)
			ACT_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_DELETE: begin
				if (!in_range) begin
					status_d = ST_INVALID;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (!in_range) begin
					status_d = ST_INVALID;
				end
			end
		endcase
		ok = status_d == ST_OK;
	end

	// insert past the end clamps to an append
	always_comb begin
		cmd.fire = accept && ok;
		cmd.act  = req.data.action;
		if (req.data.action == ACT_INSERT && !in_range) begin
			cmd.at = cnt_x[POS_W-1:0];
		end else begin
			cmd.at = req.data.position;
		end
	end

	// cell row
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_hit  [DEPTH];
	logic [DATA_W-1:0] root;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lower;
		logic [DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_low
			assign lower = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_up
			assign upper = cell_data[i+1];
		end
		iida_cell #(
			.INDEX  (i),
			.DATA_W (DATA_W)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.sel   (sel_q),
			.word  (word),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	// non-read requests leave sel_q.en low, so the root settles to zero
	iida_or_tree #(
		.N      (DEPTH),
		.W      (DATA_W),
		.LEVELS (LEVELS)
	) u_tree (
		.clk  (clk),
		.leaf (cell_hit),
		.root (root)
	);

	assign done = (state_q == S_WAIT) && (wait_q == '0) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wait_q      <= '0;
			sel_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_WAIT;
						count_q  <= count_d;
						wait_q   <= WAIT_W'(LEVELS);
						sel_q.en <= ok && req.data.action == ACT_READ;
						sel_q.at <= req.data.position;
					end
				end
				S_WAIT: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - WAIT_W'(1);
					end else if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			len_q    <= LEN_W'(count_d);
		end
		if (done) begin
			rsp_q.status     <= status_q;
			rsp_q.read_value <= VALUE_W'(root);
			rsp_q.length     <= len_q;
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

`default_nettype wire

[hw/rtl/iida_cell.sv]
// One storage cell of the array chain: holds a word, takes its neighbor's word on shifts.
// Depends on iida_pkg.
`default_nettype none

module iida_cell
	import iida_pkg::*;
#(
	parameter int INDEX  = 0,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire cmd_t              cmd,
	input  wire sel_t              sel,
	input  wire logic [DATA_W-1:0] word,
	input  wire logic [DATA_W-1:0] lower,
	input  wire logic [DATA_W-1:0] upper,
	output logic      [DATA_W-1:0] data,
	output logic      [DATA_W-1:0] hit
);

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			case (cmd.act)
				ACT_INSERT: begin
					if (IDX == cmd.at) begin
						data_q <= word;
					end else if (IDX > cmd.at) begin
						data_q <= lower;
					end
				end
				ACT_DELETE: begin
					if (IDX >= cmd.at) begin
						data_q <= upper;
					end
				end
				ACT_WRITE: begin
					if (IDX == cmd.at) begin
						data_q <= word;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign data = data_q;
	assign hit  = (sel.en && sel.at == IDX) ? data_q : '0;

endmodule

`default_nettype wire

[hw/rtl/iida_or_tree.sv]
// Registered 4-ary OR reduction; collects the one selected cell word.
// No package dependency.
`default_nettype none

module iida_or_tree #(
	parameter int N      = 64,
	parameter int W      = 32,
	parameter int LEVELS = 3
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] leaf [N],
	output logic      [W-1:0] root
);

	logic [W-1:0] lvl [1:LEVELS][N];
	logic [W-1:0] kid [1:LEVELS][N][4];

	for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
		for (genvar j = 0; j < N; j++) begin : g_node
			for (genvar c = 0; c < 4; c++) begin : g_kid
				if (4 * j + c < N) begin : g_in
					if (k == 1) begin : g_leaf
						assign kid[k][j][c] = leaf[4 * j + c];
					end else begin : g_up
						assign kid[k][j][c] = lvl[k-1][4 * j + c];
					end
				end else begin : g_pad
					assign kid[k][j][c] = '0;
				end
			end
			always_ff @(posedge clk) begin
				lvl[k][j] <= kid[k][j][0] | kid[k][j][1] | kid[k][j][2] | kid[k][j][3];
			end
		end
	end

	assign root = lvl[LEVELS][0];

endmodule

`default_nettype wire

[hw/rtl/iida_checker.sv]
// Port-level checks for indexed_insert_delete_array_core, bound to the top level.
// Depends on iida_pkg and the top level.
`default_nettype none

module iida_checker
	import iida_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire status_t            rsp_status,
	input wire logic [VALUE_W-1:0] rsp_read_value,
	input wire logic [LEN_W-1:0]   rsp_length
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_read_value)
			&& $stable(rsp_length))
		else $error("response changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
		else $error("failed request returned data");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_length == LEN_W'(DEPTH))
		else $error("full status with short length");

endmodule

bind indexed_insert_delete_array_core iida_checker #(
	.DEPTH (DEPTH)
) u_iida_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.data.status),
	.rsp_read_value (rsp.data.read_value),
	.rsp_length     (rsp.data.length)
);

`default_nettype wire
